### hdl/golomb_rice_block_encoder_defines.svh
// Assertion macros shared by the encoder RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef GOLOMB_RICE_BLOCK_ENCODER_DEFINES_SVH
`define GOLOMB_RICE_BLOCK_ENCODER_DEFINES_SVH

// same-cycle implication
`define GRBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GRBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/grbe_pkg.sv
// Shared constants and types of the Golomb-Rice block encoder.
// No dependencies.
`default_nettype none

package grbe_pkg;

    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int SEG_VAL_W     = 17;
    localparam int SEG_LEN_W     = 8;

    localparam logic [4:0]  K_LIMIT      = 5'd16;
    localparam logic [16:0] MAX_QUOTIENT = 17'd255;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_FACTOR = 1'b1;

    localparam logic [15:0] BLOCK_SIZE_RESET       = 16'd1024;
    localparam logic [7:0]  PARTITION_FACTOR_RESET = 8'd1;

    typedef struct packed {
        logic [BYTE_W-1:0]    acc;
        logic [2:0]           count;
        logic [SEG_VAL_W-1:0] seg_val;
        logic [SEG_LEN_W-1:0] seg_len;
        logic                 unary;
    } pack_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic [2:0]        count;
        logic [3:0]        take;
        logic              full;
    } pack_res_t;

endpackage

`default_nettype wire

### hdl/grbe_bit_packer.sv
// Shared shift unit: moves the next run of segment bits into the byte accumulator.
// Depends on grbe_pkg.
`default_nettype none

module grbe_bit_packer (
    input  wire grbe_pkg::pack_req_t req,
    output grbe_pkg::pack_res_t      res
);

    logic [3:0]                       room;
    logic [3:0]                       take;
    logic [grbe_pkg::SEG_LEN_W-1:0]   shamt;
    logic [grbe_pkg::SEG_VAL_W-1:0]   shifted;
    logic [8:0]                       mask_w;
    logic [grbe_pkg::BYTE_W-1:0]      bits;
    logic [15:0]                      acc_w;
    logic [3:0]                       count_w;

    always_comb
    begin
        room    = 4'd8 - {1'b0, req.count};
        take    = (req.seg_len < {4'd0, room}) ? req.seg_len[3:0] : room;
        shamt   = req.seg_len - {4'd0, take};
        shifted = req.seg_val >> shamt[4:0];
        mask_w  = (9'd1 << take) - 9'd1;
        bits    = req.unary ? mask_w[7:0] : (shifted[7:0] & mask_w[7:0]);
        acc_w   = ({8'd0, req.acc} << take) | {8'd0, bits};
        count_w = {1'b0, req.count} + take;

        res.acc   = acc_w[7:0];
        res.take  = take;
        res.full  = (count_w == 4'd8);
        res.count = count_w[2:0];
    end

endmodule

`default_nettype wire

### hdl/golomb_rice_block_encoder.sv
// Top level of the Golomb-Rice block encoder: sequencer, position counters, output register.
// Depends on grbe_pkg, grbe_bit_packer and golomb_rice_block_encoder_defines.svh.
//
// Residuals are zigzag mapped and Rice coded into an MSB-first byte stream, with an 8-bit
// Rice parameter at each partition start and a 2-bit predictor code at each block start.
// One request is handled at a time: accept, a prepare state, then three emit phases
// (header, unary run, zero plus remainder) through one shared bit packer that moves up to
// the rest of the current byte per cycle. Each cycle that completes a byte waits while the
// output register is still held by the sink.
`default_nettype none
`include "golomb_rice_block_encoder_defines.svh"

module golomb_rice_block_encoder (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [grbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [grbe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                kind,
    input  wire signed [16:0]                  residual,
    input  wire [4:0]                          rice_k,
    input  wire [1:0]                          predictor_code,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [7:0]                         out_byte,
    output logic                               last_of_run,
    output logic                               quotient_overflow
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_HDR   = 3'd2;
    localparam logic [2:0] S_UNARY = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [15:0] block_size_reg;
    logic [7:0]  partition_reg;
    logic [7:0]  acc_reg, acc_next;
    logic [2:0]  count_reg, count_next;
    logic [15:0] sample_reg, sample_next;
    logic [7:0]  block_reg, block_next;
    logic [4:0]  cur_k_reg, cur_k_next;
    logic [5:0]  bytes_left_reg, bytes_left_next;
    logic        out_valid_reg, out_valid_next;

    logic        kind_reg;
    logic [16:0] residual_reg;
    logic [4:0]  rice_k_reg;
    logic [1:0]  pcode_reg;
    logic [16:0] seg_val_reg, seg_val_next;
    logic [7:0]  seg_len_reg, seg_len_next;
    logic [7:0]  q_reg, q_next;
    logic [15:0] tail_val_reg, tail_val_next;
    logic [4:0]  tail_len_reg, tail_len_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_reg, last_next;
    logic        ovf_reg, ovf_next;

    grbe_pkg::pack_req_t pack_req;
    grbe_pkg::pack_res_t pack_res;

    logic [16:0] zz;
    logic        block_start, part_start;
    logic [4:0]  k_sat, k_use;
    logic [16:0] q_full;
    logic [16:0] rem_mask;
    logic [3:0]  hdr_len;
    logic [8:0]  total_bits;
    logic [16:0] samp_inc;
    logic [8:0]  blk_inc;
    logic [15:0] bsz;
    logic [7:0]  pf;
    logic        out_free;
    logic        advance;
    logic [7:0]  seg_left;
    logic [15:0] pad_w;

    grbe_bit_packer u_packer (
        .req (pack_req),
        .res (pack_res)
    );

    always_comb
    begin
        zz          = residual_reg[16] ? {~residual_reg[15:0], 1'b1}
                                       : {residual_reg[15:0], 1'b0};
        block_start = (sample_reg == 16'd0);
        part_start  = block_start && (block_reg == 8'd0);
        k_sat       = (rice_k_reg > grbe_pkg::K_LIMIT) ? grbe_pkg::K_LIMIT : rice_k_reg;
        k_use       = part_start ? k_sat : cur_k_reg;
        q_full      = zz >> k_use;
        rem_mask    = (17'd1 << k_use) - 17'd1;
        hdr_len     = part_start ? 4'd10 : (block_start ? 4'd2 : 4'd0);
        total_bits  = {6'd0, count_reg} + {5'd0, hdr_len} + {1'b0, q_full[7:0]}
                    + {4'd0, k_use} + 9'd1;
        bsz         = (block_size_reg == 16'd0) ? 16'd1 : block_size_reg;
        pf          = (partition_reg == 8'd0) ? 8'd1 : partition_reg;
        samp_inc    = {1'b0, sample_reg} + 17'd1;
        blk_inc     = {1'b0, block_reg} + 9'd1;
        out_free    = !out_valid_reg || out_ready;
        pad_w       = {8'd0, acc_reg} << (4'd8 - {1'b0, count_reg});

        pack_req.acc     = acc_reg;
        pack_req.count   = count_reg;
        pack_req.seg_val = seg_val_reg;
        pack_req.seg_len = seg_len_reg;
        pack_req.unary   = (state_reg == S_UNARY);

        advance  = !pack_res.full || out_free;
        seg_left = seg_len_reg - {4'd0, pack_res.take};
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        sample_next     = sample_reg;
        block_next      = block_reg;
        cur_k_next      = cur_k_reg;
        bytes_left_next = bytes_left_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        seg_val_next    = seg_val_reg;
        seg_len_next    = seg_len_reg;
        q_next          = q_reg;
        tail_val_next   = tail_val_reg;
        tail_len_next   = tail_len_reg;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        ovf_next        = ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (kind_reg)
                begin
                    if (count_reg == 3'd0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = pad_w[7:0];
                        last_next      = 1'b1;
                        ovf_next       = 1'b0;
                        acc_next       = 8'd0;
                        count_next     = 3'd0;
                        state_next     = S_IDLE;
                    end
                end
                else if (q_full > grbe_pkg::MAX_QUOTIENT)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = 8'd0;
                        last_next      = 1'b1;
                        ovf_next       = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    if (part_start)
                    begin
                        cur_k_next = k_use;
                    end
                    seg_val_next    = {7'd0, 3'd0, k_use, pcode_reg};
                    seg_len_next    = {4'd0, hdr_len};
                    q_next          = q_full[7:0];
                    tail_val_next   = zz[15:0] & rem_mask[15:0];
                    tail_len_next   = k_use;
                    bytes_left_next = total_bits[8:3];
                    if (samp_inc >= {1'b0, bsz})
                    begin
                        sample_next = 16'd0;
                        block_next  = (blk_inc >= {1'b0, pf}) ? 8'd0 : blk_inc[7:0];
                    end
                    else
                    begin
                        sample_next = samp_inc[15:0];
                    end
                    state_next = S_HDR;
                end
            end
            S_HDR, S_UNARY, S_TAIL:
            begin
                if (advance)
                begin
                    acc_next     = pack_res.full ? 8'd0 : pack_res.acc;
                    count_next   = pack_res.count;
                    seg_len_next = seg_left;
                    if (pack_res.full)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = pack_res.acc;
                        last_next       = (bytes_left_reg == 6'd1);
                        ovf_next        = 1'b0;
                        bytes_left_next = bytes_left_reg - 6'd1;
                    end
                    if (seg_left == 8'd0)
                    begin
                        priority case (state_reg)
                            S_HDR:
                            begin
                                seg_len_next = q_reg;
                                state_next   = S_UNARY;
                            end
                            S_UNARY:
                            begin
                                seg_val_next = {1'b0, tail_val_reg};
                                seg_len_next = {3'd0, tail_len_reg} + 8'd1;
                                state_next   = S_TAIL;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            block_size_reg <= grbe_pkg::BLOCK_SIZE_RESET;
            partition_reg  <= grbe_pkg::PARTITION_FACTOR_RESET;
            acc_reg        <= 8'd0;
            count_reg      <= 3'd0;
            sample_reg     <= 16'd0;
            block_reg      <= 8'd0;
            cur_k_reg      <= 5'd0;
            bytes_left_reg <= 6'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            count_reg      <= count_next;
            sample_reg     <= sample_next;
            block_reg      <= block_next;
            cur_k_reg      <= cur_k_next;
            bytes_left_reg <= bytes_left_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    grbe_pkg::REG_BLOCK_SIZE:       block_size_reg <= cfg_data;
                    grbe_pkg::REG_PARTITION_FACTOR: partition_reg  <= cfg_data[7:0];
                    default:                        block_size_reg <= block_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg     <= kind;
            residual_reg <= residual;
            rice_k_reg   <= rice_k;
            pcode_reg    <= predictor_code;
        end
        seg_val_reg  <= seg_val_next;
        seg_len_reg  <= seg_len_next;
        q_reg        <= q_next;
        tail_val_reg <= tail_val_next;
        tail_len_reg <= tail_len_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        ovf_reg      <= ovf_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign last_of_run       = last_reg;
    assign quotient_overflow = ovf_reg;

    `GRBE_ASSERT_NOW(a_byte_count_left, (state_reg == S_HDR || state_reg == S_UNARY || state_reg == S_TAIL) && pack_res.full && advance, bytes_left_reg != 6'd0, "byte emitted beyond computed count")
    `GRBE_ASSERT_NEXT(a_all_bytes_sent, state_reg == S_TAIL && state_next == S_IDLE, bytes_left_reg == 6'd0, "request ended with bytes still owed")
    `GRBE_ASSERT_NOW(a_hdr_len, state_reg == S_HDR, seg_len_reg <= 8'd10, "header segment too long")
    `GRBE_ASSERT_NOW(a_ovf_form, out_valid_reg && ovf_reg, last_reg && out_byte_reg == 8'd0, "overflow result malformed")

endmodule

`default_nettype wire

### dv/grbe_stream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Golomb-Rice block encoder: predicts the coded bytes of every accepted
// request and compares them with the bytes handed out. Depends on grbe_pkg.
module grbe_stream_checker #(
    parameter logic FINISH_KIND = 1'b1
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [grbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [grbe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                in_valid,
    input  wire                                in_ready,
    input  wire                                kind,
    input  wire signed [16:0]                  residual,
    input  wire [4:0]                          rice_k,
    input  wire [1:0]                          predictor_code,
    input  wire                                out_valid,
    input  wire                                out_ready,
    input  wire [7:0]                          out_byte,
    input  wire                                last_of_run,
    input  wire                                quotient_overflow,
    output int unsigned                        mismatches,
    output int unsigned                        bytes_waiting,
    output int unsigned                        bytes_checked,
    output int unsigned                        overflows_seen
);

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
        logic       overflow;
    } coded_byte_t;

    coded_byte_t expected_bytes[$];
    coded_byte_t request_bytes[$];

    logic [7:0]  bit_acc;
    int unsigned bit_count;
    logic [15:0] sample_pos;
    logic [7:0]  block_pos;
    logic [4:0]  part_k;
    logic [15:0] block_size_reg;
    logic [7:0]  part_factor_reg;

    task report_mismatch(input string what);
        begin
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        end
    endtask

    task append_request_byte(input logic [7:0] code, input logic ovf);
        coded_byte_t entry;
        begin
            entry         = '{code, 1'b0, ovf};
            request_bytes = {request_bytes, entry};
        end
    endtask

    task shift_in_bit(input logic b);
        begin
            bit_acc = {bit_acc[6:0], b};
            bit_count++;
            if (bit_count == 8)
            begin
                append_request_byte(bit_acc, 1'b0);
                bit_acc   = '0;
                bit_count = 0;
            end
        end
    endtask

    task shift_in_field(input logic [16:0] value, input int width);
        begin
            for (int i = width - 1; i >= 0; i--)
                shift_in_bit(value[i]);
        end
    endtask

    task predict_request(input logic knd, input logic signed [16:0] res,
                         input logic [4:0] rk, input logic [1:0] pc);
        int          value;
        logic [16:0] mapped;
        logic [7:0]  padded;
        logic [4:0]  k;
        int unsigned quo;
        int unsigned bsz;
        int unsigned pf;
        logic        blk_start;
        logic        part_start;
        coded_byte_t entry;
        begin
            request_bytes.delete();
            if (knd == FINISH_KIND)
            begin
                if (bit_count != 0)
                begin
                    padded = bit_acc << (8 - bit_count);
                    append_request_byte(padded, 1'b0);
                end
                bit_acc   = '0;
                bit_count = 0;
            end
            else
            begin
                value      = res;
                mapped     = (value < 0) ? 17'(-2 * value - 1) : 17'(2 * value);
                blk_start  = (sample_pos == 16'd0);
                part_start = blk_start && (block_pos == 8'd0);
                k          = part_start ? ((rk > grbe_pkg::K_LIMIT) ? grbe_pkg::K_LIMIT : rk)
                                        : part_k;
                quo        = mapped >> k;
                if (quo > grbe_pkg::MAX_QUOTIENT)
                begin
                    append_request_byte(8'h00, 1'b1);
                end
                else
                begin
                    if (part_start)
                    begin
                        part_k = k;
                        shift_in_field({12'd0, k}, 8);
                    end
                    if (blk_start)
                        shift_in_field({15'd0, pc}, 2);
                    repeat (quo) shift_in_bit(1'b1);
                    shift_in_bit(1'b0);
                    shift_in_field(mapped & ((17'd1 << k) - 17'd1), int'(k));

                    bsz = (block_size_reg == 16'd0) ? 1 : block_size_reg;
                    pf  = (part_factor_reg == 8'd0) ? 1 : part_factor_reg;
                    if (32'(sample_pos) + 1 >= bsz)
                    begin
                        sample_pos = '0;
                        if (32'(block_pos) + 1 >= pf)
                            block_pos = '0;
                        else
                            block_pos++;
                    end
                    else
                        sample_pos++;
                end
            end
            foreach (request_bytes[i])
            begin
                entry          = request_bytes[i];
                entry.last     = (i == request_bytes.size() - 1);
                expected_bytes = {expected_bytes, entry};
            end
        end
    endtask

    task check_result;
        coded_byte_t want;
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected result byte %02h", out_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.code_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.code_byte));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              last_of_run, want.last));
                if (quotient_overflow !== want.overflow)
                    report_mismatch($sformatf("quotient_overflow %b, expected %b",
                                              quotient_overflow, want.overflow));
                if (want.overflow)
                    overflows_seen++;
                bytes_checked++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            bit_acc         = '0;
            bit_count       = 0;
            sample_pos      = '0;
            block_pos       = '0;
            part_k          = '0;
            block_size_reg  = grbe_pkg::BLOCK_SIZE_RESET;
            part_factor_reg = grbe_pkg::PARTITION_FACTOR_RESET;
            mismatches      = 0;
            bytes_checked   = 0;
            overflows_seen  = 0;
            bytes_waiting  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == grbe_pkg::REG_BLOCK_SIZE)
                    block_size_reg = cfg_data[15:0];
                else if (cfg_index == grbe_pkg::REG_PARTITION_FACTOR)
                    part_factor_reg = cfg_data[7:0];
            end
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_request(kind, residual, rice_k, predictor_code);
            bytes_waiting <= expected_bytes.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Top of the encoder testbench: clock, reset, register writes, request stimulus and verdict.
// Depends on grbe_pkg, golomb_rice_block_encoder and grbe_stream_checker.
module testbench;

    localparam int   CLK_PERIOD    = 10;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 50;
    localparam int   IDLE_PERCENT  = 27;
    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_FINISH   = 1'b1;

    logic                              clk            = 1'b0;
    logic                              rst_n          = 1'b0;
    logic                              cfg_we         = 1'b0;
    logic [grbe_pkg::CFG_IDX_W-1:0]    cfg_index      = '0;
    logic [grbe_pkg::CFG_DATA_W-1:0]   cfg_data       = '0;
    logic                              in_valid       = 1'b0;
    logic                              kind           = 1'b0;
    logic signed [16:0]                residual       = '0;
    logic [4:0]                        rice_k         = '0;
    logic [1:0]                        predictor_code = '0;
    logic                              out_ready      = 1'b0;
    logic                              steady_flow    = 1'b0;
    wire                               in_ready;
    wire                               out_valid;
    wire [7:0]                         out_byte;
    wire                               last_of_run;
    wire                               quotient_overflow;

    int unsigned mismatches;
    int unsigned bytes_waiting;
    int unsigned bytes_checked;
    int unsigned overflows_seen;
    int unsigned quiet_cycles   = 0;
    int unsigned requests_sent  = 0;
    int unsigned finishes_sent  = 0;
    int unsigned settings_used  = 0;

    golomb_rice_block_encoder i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .residual          (residual),
        .rice_k            (rice_k),
        .predictor_code    (predictor_code),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .last_of_run       (last_of_run),
        .quotient_overflow (quotient_overflow)
    );

    grbe_stream_checker #(
        .FINISH_KIND (KIND_FINISH)
    ) i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .residual          (residual),
        .rice_k            (rice_k),
        .predictor_code    (predictor_code),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .last_of_run       (last_of_run),
        .quotient_overflow (quotient_overflow),
        .mismatches        (mismatches),
        .bytes_waiting     (bytes_waiting),
        .bytes_checked     (bytes_checked),
        .overflows_seen    (overflows_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        out_ready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PERCENT);

    // no request or result moving for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("[%0t] timeout: nothing moved for %0d cycles, %0d bytes outstanding",
                         $time, STALL_LIMIT, bytes_waiting);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task send_request(input logic knd, input logic signed [16:0] res,
                      input logic [4:0] rk, input logic [1:0] pc);
        begin
            if (!steady_flow)
                while ($urandom_range(99, 0) < IDLE_PERCENT)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
            in_valid       <= 1'b1;
            kind           <= knd;
            residual       <= res;
            rice_k         <= rk;
            predictor_code <= pc;
            do @(posedge clk); while (!in_ready);
            requests_sent++;
            if (knd == KIND_FINISH)
                finishes_sent++;
        end
    endtask

    task wait_for_drain;
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (bytes_waiting != 0);
        end
    endtask

    task configure(input logic [15:0] bsz, input logic [7:0] pf);
        begin
            wait_for_drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= grbe_pkg::REG_BLOCK_SIZE;
            cfg_data  <= bsz;
            @(posedge clk);
            cfg_index <= grbe_pkg::REG_PARTITION_FACTOR;
            cfg_data  <= {8'($urandom), pf};
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
            settings_used++;
        end
    endtask

    task send_random_request;
        logic signed [16:0] res;
        logic [4:0]         rk;
        begin
            res = 17'($urandom);
            res = res >>> $urandom_range(16, 0);
            rk  = ($urandom_range(99, 0) < 85) ? 5'($urandom_range(16, 0))
                                               : 5'($urandom_range(31, 17));
            if ($urandom_range(99, 0) < 6)
                send_request(KIND_FINISH, res, rk, 2'($urandom));
            else
                send_request(KIND_SAMPLE, res, rk, 2'($urandom));
            if ($urandom_range(99, 0) < 3)
                wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        send_request(KIND_SAMPLE, 17'sd128, 5'd0, 2'd3);      // overflow at partition start
        send_request(KIND_SAMPLE, -17'sd128, 5'd0, 2'd2);     // longest unary run
        send_request(KIND_SAMPLE, 17'sd5, 5'd31, 2'd1);
        send_request(KIND_FINISH, 17'sd0, 5'd0, 2'd0);
        send_request(KIND_FINISH, 17'sd0, 5'd0, 2'd0);        // nothing pending

        // block size shrunk to the current position
        configure(16'd2, 8'd1);
        send_request(KIND_SAMPLE, 17'sd1, 5'd7, 2'd1);
        send_request(KIND_SAMPLE, 17'h10000, 5'd31, 2'd3);    // k saturates
        send_request(KIND_SAMPLE, 17'sd65535, 5'd0, 2'd0);
        send_request(KIND_SAMPLE, 17'sd65535, 5'd0, 2'd0);
        send_request(KIND_SAMPLE, 17'sd0, 5'd16, 2'd2);
        send_request(KIND_FINISH, 17'sd0, 5'd0, 2'd0);

        // zero registers act as one
        configure(16'd0, 8'd0);
        send_request(KIND_SAMPLE, -17'sd1, 5'd3, 2'd0);
        send_request(KIND_SAMPLE, 17'sd7, 5'd3, 2'd1);
        send_request(KIND_SAMPLE, -17'sd9, 5'd1, 2'd2);
        send_request(KIND_SAMPLE, 17'sd100, 5'd2, 2'd3);
        send_request(KIND_FINISH, 17'sd0, 5'd0, 2'd0);

        configure(16'd65535, 8'd255);
        send_request(KIND_SAMPLE, 17'sd300, 5'd5, 2'd1);
        send_request(KIND_SAMPLE, -17'sd300, 5'd0, 2'd2);
        send_request(KIND_FINISH, 17'sd0, 5'd0, 2'd0);

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:       configure(16'd3, 8'd2);
                1:       configure(16'd1, 8'd255);
                3:       configure(16'd65535, 8'd1);
                4:       configure(16'd0, 8'd3);
                default: configure(16'($urandom_range(8, 1)), 8'($urandom_range(4, 1)));
            endcase
            steady_flow <= (phase == 2);
            repeat (35) send_random_request();
        end

        steady_flow <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d finishes) under %0d register settings.",
                 requests_sent, finishes_sent, settings_used);
        $display("Compared %0d coded bytes, %0d of them dropped-quotient flags.",
                 bytes_checked, overflows_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
